[hw/rtl/slid_pkg.sv]
// ----------------------------------------------------------------------------
// slid_pkg: shared types and constants for the sorted list
// Field widths, request and status codes, and the control bundle that the
// top level hands to each cell.
// ----------------------------------------------------------------------------
package slid_pkg;

  localparam int SLID_DATA_W   = 32;
  localparam int SLID_CNT_W    = 5;
  localparam int SLID_CAPACITY = 16;

  // request kinds
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } slid_req_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_DUP      = 2'd2,
    ST_NOTFOUND = 2'd3
  } slid_status_e;

  // per-cycle commit strobes for every cell
  typedef struct packed {
    logic ins;  // shift up from the insertion point and drop the value in
    logic del;  // shift down over the removed entry
  } slid_ctrl_t;

endpackage

[hw/rtl/slid_cell.sv]
// ----------------------------------------------------------------------------
// slid_cell: one slot of the sorted list
// Holds one entry, compares it with the request value and, on commit, keeps
// its entry or takes the value or a neighbour's entry.
// ----------------------------------------------------------------------------
module slid_cell (
  input  logic                                       clk_i,
  input  slid_pkg::slid_ctrl_t                       ctrl_i,
  input  logic signed [slid_pkg::SLID_DATA_W-1:0]    value_i,
  input  logic                                       valid_i,
  input  logic                                       lt_prev_i,
  input  logic signed [slid_pkg::SLID_DATA_W-1:0]    entry_prev_i,
  input  logic signed [slid_pkg::SLID_DATA_W-1:0]    entry_next_i,
  output logic                                       lt_o,
  output logic                                       hit_o,
  output logic signed [slid_pkg::SLID_DATA_W-1:0]    entry_o
);
  import slid_pkg::*;

  logic signed [SLID_DATA_W-1:0] entry_q, entry_d;

  // compare against the request; only held slots take part
  assign lt_o  = valid_i && (entry_q < value_i);
  assign hit_o = valid_i && (entry_q == value_i);

  // next entry: lower slots keep, the insertion slot takes the value,
  // higher slots take the neighbour below (insert) or above (delete)
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (lt_o) begin
        entry_d = entry_q;
      end else if (lt_prev_i) begin
        entry_d = value_i;
      end else begin
        entry_d = entry_prev_i;
      end
    end else if (ctrl_i.del) begin
      if (!lt_o) begin
        entry_d = entry_next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[hw/rtl/sorted_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// sorted_list_insert_delete: ordered table of unique signed values
// Insert and delete requests against a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless stalled and returns one result beat per
// request from an output register the cycle after it. Every cell compares its
// entry with the request value in the same cycle and shifts with its
// neighbours on the accepting edge, so throughput is set only by the output
// register draining. The critical path is the compare in each cell, the
// CAPACITY-wide OR of the match flags into the status and fill decision, and
// the fan-out of the commit strobe back to every cell. No clearing pass is
// needed after reset: slots at or above the fill count take no part.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete #(
  parameter int CAPACITY = slid_pkg::SLID_CAPACITY
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    req_type_i,
  input  logic signed [slid_pkg::SLID_DATA_W-1:0] value_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [1:0]                              status_o,
  output logic [slid_pkg::SLID_CNT_W-1:0]         count_o
);
  import slid_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]               fill_q, fill_d;
  logic                          out_valid_q;
  slid_status_e                  status_q, status_d;
  logic [SLID_CNT_W-1:0]         count_q;
  logic                          accept;
  logic                          full, dup, found;
  slid_ctrl_t                    ctrl;
  logic [CAPACITY-1:0]           valid, lt, hit;
  logic signed [SLID_DATA_W-1:0] entry [CAPACITY];

  // input beat goes in unless a finished result is held back
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                          lt_prev;
    logic signed [SLID_DATA_W-1:0] entry_prev, entry_next;

    assign valid[i] = (CntW'(i) < fill_q);

    if (i == 0) begin : g_first
      assign lt_prev    = 1'b1;
      assign entry_prev = value_i;
    end else begin : g_mid
      assign lt_prev    = lt[i-1];
      assign entry_prev = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign entry_next = entry[i];
    end else begin : g_inner
      assign entry_next = entry[i+1];
    end

    slid_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .value_i      (value_i),
      .valid_i      (valid[i]),
      .lt_prev_i    (lt_prev),
      .entry_prev_i (entry_prev),
      .entry_next_i (entry_next),
      .lt_o         (lt[i]),
      .hit_o        (hit[i]),
      .entry_o      (entry[i])
    );
  end

  // request decision
  assign full  = (fill_q == CntW'(CAPACITY));
  assign dup   = |hit;
  assign found = |hit;

  always_comb begin
    ctrl     = '0;
    status_d = ST_OK;
    fill_d   = fill_q;
    if (req_type_i == REQ_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end else if (dup) begin
        status_d = ST_DUP;
      end else begin
        ctrl.ins = accept;
        fill_d   = fill_q + CntW'(1);
      end
    end else begin
      if (!found) begin
        status_d = ST_NOTFOUND;
      end else begin
        ctrl.del = accept;
        fill_d   = fill_q - CntW'(1);
      end
    end
  end

  // fill count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      count_q  <= SLID_CNT_W'(fill_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign count_o     = count_q;

endmodule

[hw/rtl/slid_checker.sv]
// ----------------------------------------------------------------------------
// slid_checker: port-level checks for the sorted list
// Watches result beats and checks status against the reported count.
// ----------------------------------------------------------------------------
module slid_checker #(
  parameter int CAPACITY = slid_pkg::SLID_CAPACITY
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  input  logic                                    in_stall_o,
  input  logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  input  logic [1:0]                              status_o,
  input  logic [slid_pkg::SLID_CNT_W-1:0]         count_o
);
  import slid_pkg::*;

  logic [SLID_CNT_W-1:0] prev_cnt_q;
  logic                  out_beat;
  logic                  in_beat;

  assign out_beat = out_valid_o && !out_stall_i;
  assign in_beat  = in_valid_i && !in_stall_o;

  // count carried by the last delivered beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cnt_q <= '0;
    end else if (out_beat) begin
      prev_cnt_q <= count_o;
    end
  end

  // a held result beat does not change
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(count_o))
    else $error("held result beat changed");

  // a refused request leaves the count as it was
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> count_o == prev_cnt_q)
    else $error("count moved on a refused request");

  // a successful request moves the count by one
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |->
      (count_o == prev_cnt_q + SLID_CNT_W'(1)) || (count_o == prev_cnt_q - SLID_CNT_W'(1)))
    else $error("count did not step by one");

  // full is reported only at capacity, and a beat follows every accepted item
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> count_o == SLID_CNT_W'(CAPACITY))
    else $error("full reported below capacity");

  a_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> out_valid_o)
    else $error("accepted request gave no result beat");

endmodule

bind sorted_list_insert_delete slid_checker #(.CAPACITY(CAPACITY)) u_slid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .count_o     (count_o)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sorted list insert/delete checker
// Drives insert and delete requests through the valid/stall handshake with
// random gaps on both sides, tracks the expected list contents in a small
// scoreboard class and compares every result beat, status and count, in order.
// ----------------------------------------------------------------------------
module testbench;
  import slid_pkg::*;

  localparam int                            HALF_PERIOD = 10;
  localparam int                            IDLE_LIMIT  = 2000;
  localparam int                            RAND_ITEMS  = 1500;
  localparam int                            LONG_HOLD   = 300;
  localparam logic signed [SLID_DATA_W-1:0] VAL_MIN     = 32'sh8000_0000;
  localparam logic signed [SLID_DATA_W-1:0] VAL_MAX     = 32'sh7fff_ffff;

  // one expected result beat
  typedef struct {
    slid_status_e            status;
    logic [SLID_CNT_W-1:0]   count;
  } slid_reply_t;

  // tracks the ordered list and the replies still owed by the block
  class list_tracker;
    logic signed [SLID_DATA_W-1:0] held[SLID_CAPACITY];
    int unsigned                   fill;
    slid_reply_t                   owed[$];
    int unsigned                   errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int unsigned held_count();
      return fill;
    endfunction

    function logic signed [SLID_DATA_W-1:0] held_value(int unsigned idx);
      return held[idx];
    endfunction

    // apply one accepted request to the list and queue its reply
    function void note_request(slid_req_e kind, logic signed [SLID_DATA_W-1:0] val);
      slid_reply_t r;
      int unsigned pos;
      int unsigned j;
      pos = 0;
      while (pos < fill && held[pos] < val) pos++;
      r.status = ST_OK;
      if (kind == REQ_INSERT) begin
        if (fill >= SLID_CAPACITY) begin
          r.status = ST_FULL;
        end else if (pos < fill && held[pos] == val) begin
          r.status = ST_DUP;
        end else begin
          for (j = fill; j > pos; j--) held[j] = held[j-1];
          held[pos] = val;
          fill++;
        end
      end else begin
        if (pos >= fill || held[pos] != val) begin
          r.status = ST_NOTFOUND;
        end else begin
          for (j = pos; j + 1 < fill; j++) held[j] = held[j+1];
          fill--;
        end
      end
      r.count = SLID_CNT_W'(fill);
      owed.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 30) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // compare a result beat against the oldest owed reply
    task check_reply(logic [1:0] status, logic [SLID_CNT_W-1:0] count);
      slid_reply_t exp;
      if (owed.size() == 0) begin
        report_mismatch("result beat with no request pending");
        return;
      end
      exp = owed.pop_front();
      if (status !== exp.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, exp.status));
      if (count !== exp.count)
        report_mismatch($sformatf("count %0d, expected %0d", count, exp.count));
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          req_type_i;
  logic signed [SLID_DATA_W-1:0] value_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [1:0]                    status_o;
  logic [SLID_CNT_W-1:0]         count_o;

  list_tracker tracker;
  bit          calm;
  bit          held_long;
  int unsigned replies_seen;
  int unsigned idle_cycles;
  bit          took_req;
  bit          took_reply;

  sorted_list_insert_delete DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // gap length: mostly none or short, a few long; none in calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one request beat and wait until it is taken
  task automatic send_request(input slid_req_e kind,
                              input logic signed [SLID_DATA_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // directed: empty, extremes, duplicate, absent, full
  task automatic run_directed();
    int i;
    send_request(REQ_DELETE, 32'sd7);
    send_request(REQ_INSERT, VAL_MAX);
    send_request(REQ_INSERT, VAL_MIN);
    send_request(REQ_INSERT, 32'sd0);
    send_request(REQ_INSERT, 32'sd0);
    send_request(REQ_DELETE, 32'sd5);
    send_request(REQ_DELETE, VAL_MIN);
    send_request(REQ_DELETE, VAL_MAX);
    send_request(REQ_INSERT, VAL_MIN);
    send_request(REQ_INSERT, VAL_MAX);
    for (i = 13; i >= 1; i--) send_request(REQ_INSERT, i * 1000 - 6500);
    send_request(REQ_INSERT, VAL_MIN);
    send_request(REQ_INSERT, 32'sd77);
  endtask

  // random: batches with their own insert bias and idling mode
  task automatic run_random();
    int                            n;
    int                            r;
    int unsigned                   ins_bias;
    slid_req_e                     kind;
    logic signed [SLID_DATA_W-1:0] val;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0) begin
        calm     = ($urandom_range(3) == 0);
        ins_bias = $urandom_range(30, 85);
      end
      kind = ($urandom_range(99) < ins_bias) ? REQ_INSERT : REQ_DELETE;
      r = $urandom_range(99);
      if (r < 55) begin
        val = $signed($urandom_range(40)) - 20;
      end else if (r < 75 && tracker.held_count() > 0) begin
        val = tracker.held_value($urandom_range(tracker.held_count() - 1));
      end else if (r < 82) begin
        case ($urandom_range(5))
          0: val = VAL_MIN;
          1: val = VAL_MAX;
          2: val = VAL_MIN + 1;
          3: val = VAL_MAX - 1;
          4: val = -32'sd1;
          default: val = 32'sd0;
        endcase
      end else begin
        val = $signed($urandom());
      end
      send_request(kind, val);
    end
    calm = 1'b0;
  endtask

  // receiver stall pattern, with one long hold to back the block up
  initial begin
    int n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_long && replies_seen >= 400) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        held_long = 1'b1;
      end else if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  // beat monitors and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      took_req   = (in_valid_i === 1'b1) && (in_stall_o === 1'b0);
      took_reply = (out_valid_o === 1'b1) && (out_stall_i === 1'b0);
      if (took_req) tracker.note_request(slid_req_e'(req_type_i), value_i);
      if (took_reply) begin
        tracker.check_reply(status_o, count_o);
        replies_seen++;
      end
      if (took_req || took_reply) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    tracker      = new();
    calm         = 1'b0;
    held_long    = 1'b0;
    replies_seen = 0;
    idle_cycles  = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = 1'b0;
    value_i      = '0;
    out_stall_i  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    in_valid_i <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.owed.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
